>>> hw/rtl/bds_pkg.sv
// Shared constants, register indexes and control types for the box downscaler.
package bds_pkg;

    localparam int MAX_OUT_WIDTH_DEF = 64;
    localparam int MAX_IN_DIM_DEF    = 1024;
    localparam int OUT_LIMIT         = 64;
    localparam int SUM_W             = 28;
    localparam int CNT_W             = 21;
    localparam int CH_W              = 8;
    localparam int BIN_W             = 6;
    localparam int IN_REG_W          = 11;
    localparam int OUT_REG_W         = 7;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 11;
    localparam int STEP_W            = 5;
    localparam int STORE_W           = 3 * SUM_W + CNT_W;

    localparam logic [IN_REG_W-1:0]  RST_IN_WIDTH   = IN_REG_W'(400);
    localparam logic [IN_REG_W-1:0]  RST_IN_HEIGHT  = IN_REG_W'(400);
    localparam logic [OUT_REG_W-1:0] RST_OUT_WIDTH  = OUT_REG_W'(45);
    localparam logic [OUT_REG_W-1:0] RST_OUT_HEIGHT = OUT_REG_W'(40);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_WIDTH,
        CFG_IN_HEIGHT,
        CFG_OUT_WIDTH,
        CFG_OUT_HEIGHT
    } t_cfg_idx;

    typedef struct packed {
        logic              capture;
        logic              bin_step;
        logic              bin_round;
        logic              bin_done;
        logic              rd;
        logic              acc;
        logic              avg_step;
        logic              load;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic out_free;
    } t_sts;

endpackage

>>> hw/rtl/bds_pix_if.sv
// Input pixel channel: valid/ready with one RGB pixel and a frame start flag.
interface bds_pix_if;
    logic                      valid;
    logic                      ready;
    logic                      frame_start;
    logic [bds_pkg::CH_W-1:0]  red_in;
    logic [bds_pkg::CH_W-1:0]  green_in;
    logic [bds_pkg::CH_W-1:0]  blue_in;

    modport source (output valid, frame_start, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, frame_start, red_in, green_in, blue_in, output ready);
endinterface

>>> hw/rtl/bds_res_if.sv
// Output pixel channel: valid/ready with one averaged bin and its position.
interface bds_res_if;
    logic                      valid;
    logic                      ready;
    logic [bds_pkg::BIN_W-1:0] out_x;
    logic [bds_pkg::BIN_W-1:0] out_y;
    logic [bds_pkg::CH_W-1:0]  red_out;
    logic [bds_pkg::CH_W-1:0]  green_out;
    logic [bds_pkg::CH_W-1:0]  blue_out;
    logic                      frame_end;

    modport source (output valid, out_x, out_y, red_out, green_out, blue_out, frame_end,
                    input ready);
    modport sink   (input valid, out_x, out_y, red_out, green_out, blue_out, frame_end,
                    output ready);
endinterface

>>> hw/rtl/bds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

>>> hw/rtl/bds_ctrl.sv
// Sequencer: bin divisions, line store read/update, average division, output load.
module bds_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bds_pkg::t_sts i_sts,
    output bds_pkg::t_cmd o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_BIN0, S_BIN1, S_RD, S_ACC, S_AVG, S_OUT} t_state;

    t_state                     r_state;
    logic [bds_pkg::STEP_W-1:0] r_cnt;
    logic                       c_bin_done;
    logic                       c_avg_done;

    assign c_bin_done = (r_cnt == bds_pkg::STEP_W'(bds_pkg::BIN_W - 1));
    assign c_avg_done = (r_cnt == bds_pkg::STEP_W'(bds_pkg::SUM_W - 1));
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.step      = r_cnt;
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.bin_step  = (r_state == S_BIN0) || (r_state == S_BIN1);
        o_cmd.bin_round = (r_state == S_BIN1);
        o_cmd.bin_done  = c_bin_done;
        o_cmd.rd        = (r_state == S_RD);
        o_cmd.acc       = (r_state == S_ACC);
        o_cmd.avg_step  = (r_state == S_AVG);
        o_cmd.load      = (r_state == S_OUT) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_in_valid) begin
                        r_state <= S_BIN0;
                    end
                end
                S_BIN0, S_BIN1: begin
                    if (c_bin_done) begin
                        r_cnt   <= '0;
                        r_state <= (r_state == S_BIN0) ? S_BIN1 : S_RD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_RD: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_cnt   <= '0;
                    r_state <= i_sts.emit ? S_AVG : S_IDLE;
                end
                S_AVG: begin
                    if (c_avg_done) begin
                        r_cnt   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_OUT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

>>> hw/rtl/bds_dp.sv
// Datapath: config registers, position counters, bin dividers, line store, averager.
module bds_dp #(
    parameter int MAX_OUT_WIDTH = bds_pkg::MAX_OUT_WIDTH_DEF,
    parameter int MAX_IN_DIM    = bds_pkg::MAX_IN_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bds_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bds_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_frame_start,
    input  logic [bds_pkg::CH_W-1:0]         i_red,
    input  logic [bds_pkg::CH_W-1:0]         i_green,
    input  logic [bds_pkg::CH_W-1:0]         i_blue,
    input  bds_pkg::t_cmd                    i_cmd,
    output bds_pkg::t_sts                    o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [bds_pkg::BIN_W-1:0]        o_out_x,
    output logic [bds_pkg::BIN_W-1:0]        o_out_y,
    output logic [bds_pkg::CH_W-1:0]         o_red,
    output logic [bds_pkg::CH_W-1:0]         o_green,
    output logic [bds_pkg::CH_W-1:0]         o_blue,
    output logic                             o_frame_end
);
    localparam int PW  = $clog2(MAX_IN_DIM + 1);
    localparam int PNW = PW + bds_pkg::OUT_REG_W;
    localparam int OWL = (MAX_OUT_WIDTH < bds_pkg::OUT_LIMIT) ? MAX_OUT_WIDTH
                                                              : bds_pkg::OUT_LIMIT;
    localparam int AW  = (OWL > 1) ? $clog2(OWL) : 1;
    localparam int SW  = bds_pkg::SUM_W;
    localparam int NW  = bds_pkg::CNT_W;
    localparam int CW  = bds_pkg::CH_W;
    localparam int BW  = bds_pkg::BIN_W;
    localparam int OW  = bds_pkg::OUT_REG_W;

    // configuration
    logic [bds_pkg::IN_REG_W-1:0] r_in_width, r_in_height;
    logic [OW-1:0]                r_out_width, r_out_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width   <= bds_pkg::RST_IN_WIDTH;
            r_in_height  <= bds_pkg::RST_IN_HEIGHT;
            r_out_width  <= bds_pkg::RST_OUT_WIDTH;
            r_out_height <= bds_pkg::RST_OUT_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (bds_pkg::t_cfg_idx'(i_cfg_idx))
                bds_pkg::CFG_IN_WIDTH:   r_in_width   <= i_cfg_data;
                bds_pkg::CFG_IN_HEIGHT:  r_in_height  <= i_cfg_data;
                bds_pkg::CFG_OUT_WIDTH:  r_out_width  <= i_cfg_data[OW-1:0];
                bds_pkg::CFG_OUT_HEIGHT: r_out_height <= i_cfg_data[OW-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes
    logic [PW-1:0] c_iw, c_ih;
    logic [OW-1:0] c_ow_lim, c_oh_lim, c_ow, c_oh;

    always_comb begin
        if (r_in_width == '0) c_iw = PW'(1);
        else if (32'(r_in_width) > MAX_IN_DIM) c_iw = PW'(MAX_IN_DIM);
        else c_iw = PW'(r_in_width);
        if (r_in_height == '0) c_ih = PW'(1);
        else if (32'(r_in_height) > MAX_IN_DIM) c_ih = PW'(MAX_IN_DIM);
        else c_ih = PW'(r_in_height);
        c_ow_lim = (32'(c_iw) < OWL) ? OW'(c_iw) : OW'(OWL);
        c_oh_lim = (32'(c_ih) < bds_pkg::OUT_LIMIT) ? OW'(c_ih) : OW'(bds_pkg::OUT_LIMIT);
        if (r_out_width == '0) c_ow = OW'(1);
        else if (r_out_width > c_ow_lim) c_ow = c_ow_lim;
        else c_ow = r_out_width;
        if (r_out_height == '0) c_oh = OW'(1);
        else if (r_out_height > c_oh_lim) c_oh = c_oh_lim;
        else c_oh = r_out_height;
    end

    // position and captured item
    logic [PW-1:0] r_col, r_row, r_ccol, r_crow, c_ccol, c_crow;
    logic [PW-1:0] r_iw, r_ih;
    logic [OW-1:0] r_ow, r_oh;
    logic [CW-1:0] r_red, r_green, r_blue;

    assign c_ccol = (i_frame_start || (r_col >= c_iw)) ? '0 : r_col;
    assign c_crow = (i_frame_start || (r_row >= c_ih)) ? '0 : r_row;

    // bin dividers, one quotient bit per step
    logic [PNW-1:0] r_pc, r_pr, r_rc, r_rr, c_dc, c_dr, c_rc_n, c_rr_n;
    logic [BW-1:0]  r_qc, r_qr, c_qc_n, c_qr_n;
    logic [BW-1:0]  r_bc, r_br, r_bc1, r_br1;
    logic [2:0]     c_sh;

    always_comb begin
        c_sh   = 3'(BW - 1) - i_cmd.step[2:0];
        c_dc   = PNW'(r_iw) << c_sh;
        c_dr   = PNW'(r_ih) << c_sh;
        c_rc_n = (r_rc >= c_dc) ? r_rc - c_dc : r_rc;
        c_rr_n = (r_rr >= c_dr) ? r_rr - c_dr : r_rr;
        c_qc_n = {r_qc[BW-2:0], r_rc >= c_dc};
        c_qr_n = {r_qr[BW-2:0], r_rr >= c_dr};
    end

    // line store
    logic [OWL-1:0]               r_vld;
    logic [bds_pkg::STORE_W-1:0]  c_rdata, c_old, c_wdata;
    logic [SW-1:0]                c_sr, c_sg, c_sb;
    logic [NW-1:0]                c_n;
    logic                         c_col_last, c_row_last, c_emit;
    logic [AW-1:0]                c_k;

    assign c_k   = AW'(r_bc);
    assign c_old = r_vld[c_k] ? c_rdata : '0;
    assign c_sr  = c_old[3*SW+NW-1:2*SW+NW] + SW'(r_red);
    assign c_sg  = c_old[2*SW+NW-1:SW+NW] + SW'(r_green);
    assign c_sb  = c_old[SW+NW-1:NW] + SW'(r_blue);
    assign c_n   = c_old[NW-1:0] + 1'b1;
    assign c_wdata = {c_sr, c_sg, c_sb, c_n};

    assign c_col_last = ((PW+1)'(r_ccol) + 1'b1 >= (PW+1)'(r_iw)) || (r_bc1 != r_bc);
    assign c_row_last = ((PW+1)'(r_crow) + 1'b1 >= (PW+1)'(r_ih)) || (r_br1 != r_br);
    assign c_emit     = c_col_last && c_row_last;

    bds_ram #(
        .WIDTH (bds_pkg::STORE_W),
        .DEPTH (OWL)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.acc && !c_emit),
        .i_waddr (c_k),
        .i_wdata (c_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (c_k),
        .o_rdata (c_rdata)
    );

    // averager: restoring division, three channels over one count
    logic [SW-1:0] r_dr, r_dg, r_db;
    logic [NW-1:0] r_mr, r_mg, r_mb, r_n, c_mr_n, c_mg_n, c_mb_n;
    logic [CW-1:0] r_ar, r_ag, r_ab;
    logic          c_br, c_bg, c_bb;
    logic          r_fend;

    function automatic logic [NW:0] avg_step(input logic [NW-1:0] rem, input logic msb,
                                             input logic [NW-1:0] n);
        logic [NW:0] t;
        t = {rem, msb};
        if (t >= {1'b0, n}) avg_step = {1'b1, NW'(t - {1'b0, n})};
        else avg_step = {1'b0, NW'(t)};
    endfunction

    assign {c_br, c_mr_n} = avg_step(r_mr, r_dr[SW-1], r_n);
    assign {c_bg, c_mg_n} = avg_step(r_mg, r_dg[SW-1], r_n);
    assign {c_bb, c_mb_n} = avg_step(r_mb, r_db[SW-1], r_n);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ccol  <= c_ccol;
            r_crow  <= c_crow;
            r_iw    <= c_iw;
            r_ih    <= c_ih;
            r_ow    <= c_ow;
            r_oh    <= c_oh;
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_pc    <= PNW'(c_ccol) * PNW'(c_ow);
            r_pr    <= PNW'(c_crow) * PNW'(c_oh);
            r_rc    <= PNW'(c_ccol) * PNW'(c_ow);
            r_rr    <= PNW'(c_crow) * PNW'(c_oh);
            r_qc    <= '0;
            r_qr    <= '0;
        end
        if (i_cmd.bin_step) begin
            if (i_cmd.bin_done && !i_cmd.bin_round) begin
                r_bc <= c_qc_n;
                r_br <= c_qr_n;
                r_rc <= r_pc + PNW'(r_ow);
                r_rr <= r_pr + PNW'(r_oh);
                r_qc <= '0;
                r_qr <= '0;
            end else if (i_cmd.bin_done) begin
                r_bc1 <= c_qc_n;
                r_br1 <= c_qr_n;
            end else begin
                r_rc <= c_rc_n;
                r_rr <= c_rr_n;
                r_qc <= c_qc_n;
                r_qr <= c_qr_n;
            end
        end
        if (i_cmd.acc && c_emit) begin
            r_dr   <= c_sr;
            r_dg   <= c_sg;
            r_db   <= c_sb;
            r_n    <= c_n;
            r_mr   <= '0;
            r_mg   <= '0;
            r_mb   <= '0;
            r_fend <= (OW'(r_bc) + 1'b1 == r_ow) && (OW'(r_br) + 1'b1 == r_oh);
        end
        if (i_cmd.avg_step) begin
            r_dr <= r_dr << 1;
            r_dg <= r_dg << 1;
            r_db <= r_db << 1;
            r_mr <= c_mr_n;
            r_mg <= c_mg_n;
            r_mb <= c_mb_n;
            r_ar <= {r_ar[CW-2:0], c_br};
            r_ag <= {r_ag[CW-2:0], c_bg};
            r_ab <= {r_ab[CW-2:0], c_bb};
        end
        if (i_cmd.load) begin
            o_out_x     <= r_bc;
            o_out_y     <= r_br;
            o_red       <= (r_n == '0) ? '0 : r_ar;
            o_green     <= (r_n == '0) ? '0 : r_ag;
            o_blue      <= (r_n == '0) ? '0 : r_ab;
            o_frame_end <= r_fend;
        end
    end

    // control state: counters, valid bits, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_vld       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture && i_frame_start) begin
                r_vld <= '0;
            end
            if (i_cmd.acc) begin
                r_vld[c_k] <= !c_emit;
                if ((PW+1)'(r_ccol) + 1'b1 >= (PW+1)'(r_iw)) begin
                    r_col <= '0;
                    r_row <= ((PW+1)'(r_crow) + 1'b1 >= (PW+1)'(r_ih)) ? '0
                                                                      : r_crow + 1'b1;
                end else begin
                    r_col <= r_ccol + 1'b1;
                    r_row <= r_crow;
                end
            end
            if (i_cmd.load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.emit     = c_emit;
    assign o_sts.out_free = !o_out_valid || i_out_ready;
endmodule

>>> hw/rtl/box_downscale_pixel_stream.sv
// Top level of the box-filter RGB downscaler.
// One pixel is taken at a time and occupies the block through two passes of the column and
// row shift-subtract bin dividers (current and next position), the line store read and
// update and, on pixels that close a bin, the bit-serial average divider and the load of
// the output register. The output register lets the next pixel enter while a finished bin
// waits to be taken. The single line store's valid bits are cleared at once on reset and on
// frame_start, so no clearing pass is needed.
module box_downscale_pixel_stream #(
    parameter int MAX_OUT_WIDTH = bds_pkg::MAX_OUT_WIDTH_DEF,
    parameter int MAX_IN_DIM    = bds_pkg::MAX_IN_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bds_pix_if.sink                        i_pix,
    bds_res_if.source                      o_res
);
    bds_pkg::t_cmd c_cmd;
    bds_pkg::t_sts c_sts;

    bds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_sts      (c_sts),
        .o_cmd      (c_cmd)
    );

    bds_dp #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .MAX_IN_DIM    (MAX_IN_DIM)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_frame_start (i_pix.frame_start),
        .i_red         (i_pix.red_in),
        .i_green       (i_pix.green_in),
        .i_blue        (i_pix.blue_in),
        .i_cmd         (c_cmd),
        .o_sts         (c_sts),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_out_x       (o_res.out_x),
        .o_out_y       (o_res.out_y),
        .o_red         (o_res.red_out),
        .o_green       (o_res.green_out),
        .o_blue        (o_res.blue_out),
        .o_frame_end   (o_res.frame_end)
    );

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> !i_pix.ready)
        else $error("input ready right after an accepted beat");

    a_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(!i_pix.ready))
        else $error("output loaded while input side idle");

    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_cmd.load |-> (!o_res.valid || o_res.ready))
        else $error("output register overwritten before taken");
endmodule
